// File: rtl/lfpd_pkg.sv
// Shared types, constants and helpers for the PD line-follower motor drive.
// No dependencies; every other file in rtl/ depends on this package.
package lfpd_pkg;

    localparam int SPEED_W   = 8;
    localparam int SENSOR_W  = 8;
    localparam int CFG_IDX_W = 3;
    localparam int ERR_W     = 4;
    localparam int RATE_W    = 5;
    localparam int PROD_W    = 12;
    localparam int PTERM_W   = 8;
    localparam int DRIVE_W   = 13;
    localparam int SUM_W     = 14;

    localparam logic [SENSOR_W-1:0] SENSOR_MASK = 8'b0111_1111;

    localparam logic [SPEED_W-1:0] PROP_GAIN_RST  = 8'd32;
    localparam logic [SPEED_W-1:0] DERIV_GAIN_RST = 8'd8;
    localparam logic [SPEED_W-1:0] BASE_SPEED_RST = 8'd170;
    localparam logic [SPEED_W-1:0] MAX_SPEED_RST  = 8'd255;
    localparam logic [SPEED_W-1:0] MIN_SPEED_RST  = 8'd0;

    typedef logic [SPEED_W-1:0]         t_speed;
    typedef logic [SENSOR_W-1:0]        t_sensor;
    typedef logic signed [ERR_W-1:0]    t_err;
    typedef logic signed [SUM_W-1:0]    t_sum;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN  = 3'd0,
        CFG_DERIV_GAIN = 3'd1,
        CFG_BASE_SPEED = 3'd2,
        CFG_MAX_SPEED  = 3'd3,
        CFG_MIN_SPEED  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic hit;
        t_err err;
    } t_err_map;

    // Map one lit sensor or two adjacent lit sensors to a position error.
    function automatic t_err_map map_pattern(input logic [SENSOR_W-2:0] pat);
        t_err_map m;
        m.hit = 1'b1;
        m.err = 4'sd0;
        case (pat)
            7'h01:   m.err = -4'sd6;
            7'h03:   m.err = -4'sd5;
            7'h02:   m.err = -4'sd4;
            7'h06:   m.err = -4'sd3;
            7'h04:   m.err = -4'sd2;
            7'h0C:   m.err = -4'sd1;
            7'h08:   m.err =  4'sd0;
            7'h18:   m.err =  4'sd1;
            7'h10:   m.err =  4'sd2;
            7'h30:   m.err =  4'sd3;
            7'h20:   m.err =  4'sd4;
            7'h60:   m.err =  4'sd5;
            7'h40:   m.err =  4'sd6;
            default: m.hit = 1'b0;
        endcase
        return m;
    endfunction

    // Upper clamp first, then lower clamp: min above max yields min.
    function automatic t_speed clamp_speed(input t_sum v, input t_speed hi,
                                           input t_speed lo);
        t_sum r;
        r = v;
        if (r > $signed({6'b0, hi})) r = $signed({6'b0, hi});
        if (r < $signed({6'b0, lo})) r = $signed({6'b0, lo});
        return r[SPEED_W-1:0];
    endfunction

endpackage

// File: rtl/lfpd_sens_if.sv
// Sensor sample channel: valid/ready handshake with one sensor byte per beat.
// Depends on lfpd_pkg for the payload type.
interface lfpd_sens_if;
    logic               valid;
    logic               ready;
    lfpd_pkg::t_sensor  sensor_bits;

    modport source (output valid, output sensor_bits, input ready);
    modport sink   (input valid, input sensor_bits, output ready);
endinterface

// File: rtl/lfpd_drive_if.sv
// Motor drive channel: valid/ready handshake with left and right speeds per beat.
// Depends on lfpd_pkg for the payload type.
interface lfpd_drive_if;
    logic              valid;
    logic              ready;
    lfpd_pkg::t_speed  left_speed;
    lfpd_pkg::t_speed  right_speed;

    modport source (output valid, output left_speed, output right_speed, input ready);
    modport sink   (input valid, input left_speed, input right_speed, output ready);
endinterface

// File: rtl/line_follow_pd_motor_drive.sv
// PD line follower with differential motor drive: top level.
// Depends on lfpd_pkg, lfpd_sens_if and lfpd_drive_if.
//
// One sensor beat in, one drive beat out. A beat is taken into an input
// register; from there the position error is looked up, the error change
// formed, both gain products summed, and left/right speeds clamped into the
// output register. Throughput is one beat per cycle while the sink keeps
// ready high. The input register and the output register each hold a beat,
// so a new sample is taken while a finished result waits for the sink.
// Samples that match none of the thirteen single or adjacent-pair patterns
// reuse the last error. Configuration registers (gains, base, min, max) are
// written through the plain write port and should only change while no beat
// is in flight.
module line_follow_pd_motor_drive (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [lfpd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lfpd_pkg::SPEED_W-1:0]        i_cfg_data,
    lfpd_sens_if.sink                           i_sens,
    lfpd_drive_if.source                        o_drive
);
    import lfpd_pkg::*;

    // Configuration registers
    t_speed r_prop_gain, r_deriv_gain, r_base_speed, r_max_speed, r_min_speed;

    // Input stage
    logic    r_s1_valid;
    t_sensor r_s1_sample;

    // Error state and output stage
    t_err    r_prev_err;
    logic    r_out_valid;
    t_speed  r_left, r_right;

    logic    w_out_free;
    logic    w_s1_adv;
    logic    w_in_take;

    t_err_map                   w_map;
    t_err                       n_err;
    logic signed [RATE_W-1:0]   w_rate;
    logic signed [PROD_W-1:0]   w_prod;
    logic signed [PROD_W-1:0]   w_prod_adj;
    logic signed [PTERM_W-1:0]  w_pterm;
    logic signed [DRIVE_W-1:0]  w_dterm;
    logic signed [DRIVE_W-1:0]  w_drive;
    t_sum                       w_sum_l, w_sum_r;
    t_speed                     n_left, n_right;

    // Handshake: the output register frees when empty or being taken;
    // the input register advances when it holds a beat and the output is free.
    assign w_out_free  = !r_out_valid || o_drive.ready;
    assign w_s1_adv    = r_s1_valid && w_out_free;
    assign i_sens.ready = !r_s1_valid || w_out_free;
    assign w_in_take   = i_sens.valid && i_sens.ready;

    assign o_drive.valid       = r_out_valid;
    assign o_drive.left_speed  = r_left;
    assign o_drive.right_speed = r_right;

    // Datapath from input register to output register
    always_comb begin
        w_map      = map_pattern(r_s1_sample[SENSOR_W-2:0]);
        n_err      = w_map.hit ? w_map.err : r_prev_err;
        w_rate     = RATE_W'(n_err) - RATE_W'(r_prev_err);
        w_prod     = PROD_W'(n_err) * PROD_W'($signed({1'b0, r_prop_gain}));
        // Bias negatives by 15 so the shift truncates toward zero
        w_prod_adj = w_prod + (w_prod[PROD_W-1] ? 12'sd15 : 12'sd0);
        w_pterm    = PTERM_W'(w_prod_adj >>> 4);
        w_dterm    = DRIVE_W'(w_rate) * DRIVE_W'($signed({1'b0, r_deriv_gain}));
        w_drive    = DRIVE_W'(w_pterm) + w_dterm;
        w_sum_l    = SUM_W'($signed({1'b0, r_base_speed})) + SUM_W'(w_drive);
        w_sum_r    = SUM_W'($signed({1'b0, r_base_speed})) - SUM_W'(w_drive);
        n_left     = clamp_speed(w_sum_l, r_max_speed, r_min_speed);
        n_right    = clamp_speed(w_sum_r, r_max_speed, r_min_speed);
    end

    // Configuration writes; out-of-range indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain  <= PROP_GAIN_RST;
            r_deriv_gain <= DERIV_GAIN_RST;
            r_base_speed <= BASE_SPEED_RST;
            r_max_speed  <= MAX_SPEED_RST;
            r_min_speed  <= MIN_SPEED_RST;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PROP_GAIN:  r_prop_gain  <= i_cfg_data;
                CFG_DERIV_GAIN: r_deriv_gain <= i_cfg_data;
                CFG_BASE_SPEED: r_base_speed <= i_cfg_data;
                CFG_MAX_SPEED:  r_max_speed  <= i_cfg_data;
                CFG_MIN_SPEED:  r_min_speed  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_prev_err  <= '0;
        end else begin
            if (w_in_take)     r_s1_valid <= 1'b1;
            else if (w_s1_adv) r_s1_valid <= 1'b0;

            if (w_s1_adv)            r_out_valid <= 1'b1;
            else if (o_drive.ready)  r_out_valid <= 1'b0;

            // Advance the error state only when a beat moves to the output
            if (w_s1_adv) r_prev_err <= n_err;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_take) r_s1_sample <= i_sens.sensor_bits;
        if (w_s1_adv) begin
            r_left  <= n_left;
            r_right <= n_right;
        end
    end

    // Error state never leaves the mapped range
    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_prev_err >= -4'sd6) && (r_prev_err <= 4'sd6))
        else $error("position error out of range");

    // An unmapped sample leaves the error state unchanged
    a_unmapped_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_adv && !w_map.hit) |=> $stable(r_prev_err))
        else $error("unmapped sample changed error state");

    // A held input beat is not overwritten while it waits
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_s1_adv) |=> (r_s1_valid && $stable(r_s1_sample)))
        else $error("input register lost a waiting beat");

    // A stalled result stays in place
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_drive.ready) |=> (r_out_valid && $stable(r_left)
                                             && $stable(r_right)))
        else $error("output register lost a waiting beat");

endmodule
